// ===== design/mlfq_pkg.sv =====
// Shared types and constants for the feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;
	localparam int SLOTS   = 64;
	localparam int SLOT_W  = 6;
	localparam int LEVELS  = 5;
	localparam int LVL_W   = 3;
	localparam int BURST_W = 5;

	localparam logic [2:0] CMD_CREATE  = 3'd0;
	localparam logic [2:0] CMD_PICK    = 3'd1;
	localparam logic [2:0] CMD_TICK    = 3'd2;
	localparam logic [2:0] CMD_YIELD   = 3'd3;
	localparam logic [2:0] CMD_SLEEP   = 3'd4;
	localparam logic [2:0] CMD_WAKE    = 3'd5;
	localparam logic [2:0] CMD_EXIT    = 3'd6;
	localparam logic [2:0] CMD_COLLECT = 3'd7;

	localparam logic [2:0] TS_UNUSED   = 3'd0;
	localparam logic [2:0] TS_RUNNABLE = 3'd1;
	localparam logic [2:0] TS_RUNNING  = 3'd2;
	localparam logic [2:0] TS_SLEEPING = 3'd3;
	localparam logic [2:0] TS_ZOMBIE   = 3'd4;

	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_NO_TASK = 2'd1;
	localparam logic [1:0] STAT_BAD     = 2'd2;

	localparam logic [15:0] AGING_RST = 16'd40;

	typedef enum logic [1:0] {RD_SWEEP, RD_SLOT, RD_BEST} rd_kind_t;

	typedef enum logic [2:0] {
		C_IDLE, C_SWEEP, C_DRAIN, C_SINGLE, C_SINGLE_WB, C_PICK_RD, C_PICK_WB, C_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic [2:0]         st;
		logic [LVL_W-1:0]   lvl;
		logic [BURST_W-1:0] burst;
		logic [15:0]        wcnt;
		logic [31:0]        run;
		logic [31:0]        slp;
		logic [31:0]        disp;
		logic [31:0]        chan;
		logic [63:0]        stamp;
	} row_t;

	typedef struct packed {
		logic [31:0]       run_count;
		logic [15:0]       wait_ticks;
		logic [31:0]       sleep_ticks;
		logic [31:0]       run_ticks;
		logic [LVL_W-1:0]  level;
		logic [SLOT_W-1:0] chosen_slot;
		logic [1:0]        status;
	} result_t;

	typedef struct packed {
		logic     start;
		logic     rd_en;
		rd_kind_t rd_kind;
		logic     no_task;
		logic     load_out;
	} ctl_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       idx_last;
		logic       found;
		logic       out_free;
	} sts_t;

	function automatic logic [31:0] sat32(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction
endpackage

// ===== design/mlfq_ctrl.sv =====
// Controller state machine sequencing table sweeps and single-slot updates.
`timescale 1ns / 1ps
module mlfq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2:0]        in_cmd,
	output logic              in_ready,
	input  mlfq_pkg::sts_t    sts,
	output mlfq_pkg::ctl_t    ctl
);
	mlfq_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlfq_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mlfq_pkg::C_IDLE: begin
				if (in_valid) begin
					if (in_cmd inside {mlfq_pkg::CMD_PICK, mlfq_pkg::CMD_TICK,
						mlfq_pkg::CMD_WAKE}) begin
						state_d = mlfq_pkg::C_SWEEP;
					end else begin
						state_d = mlfq_pkg::C_SINGLE;
					end
				end
			end
			mlfq_pkg::C_SWEEP: begin
				if (sts.idx_last) state_d = mlfq_pkg::C_DRAIN;
			end
			mlfq_pkg::C_DRAIN: begin
				state_d = (sts.cmd == mlfq_pkg::CMD_PICK) ? mlfq_pkg::C_PICK_RD
					: mlfq_pkg::C_FINISH;
			end
			mlfq_pkg::C_SINGLE:    state_d = mlfq_pkg::C_SINGLE_WB;
			mlfq_pkg::C_SINGLE_WB: state_d = mlfq_pkg::C_FINISH;
			mlfq_pkg::C_PICK_RD: begin
				state_d = sts.found ? mlfq_pkg::C_PICK_WB : mlfq_pkg::C_FINISH;
			end
			mlfq_pkg::C_PICK_WB:   state_d = mlfq_pkg::C_FINISH;
			mlfq_pkg::C_FINISH: begin
				if (sts.out_free) state_d = mlfq_pkg::C_IDLE;
			end
			default: state_d = mlfq_pkg::C_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		ctl          = '0;
		ctl.rd_kind  = mlfq_pkg::RD_SWEEP;
		case (state_q)
			mlfq_pkg::C_IDLE: begin
				in_ready  = 1'b1;
				ctl.start = in_valid;
			end
			mlfq_pkg::C_SWEEP: begin
				ctl.rd_en = 1'b1;
			end
			mlfq_pkg::C_SINGLE: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_kind = mlfq_pkg::RD_SLOT;
			end
			mlfq_pkg::C_PICK_RD: begin
				ctl.rd_en   = sts.found;
				ctl.rd_kind = mlfq_pkg::RD_BEST;
				ctl.no_task = !sts.found;
			end
			mlfq_pkg::C_FINISH: begin
				ctl.load_out = sts.out_free;
			end
			default: ;
		endcase
	end
endmodule

// ===== design/mlfq_datapath.sv =====
// Slot table memory, update logic, pick selection and output register.
`timescale 1ns / 1ps
module mlfq_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            in_cmd,
	input  logic [5:0]            in_slot,
	input  logic [31:0]           in_chan,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  mlfq_pkg::ctl_t        ctl,
	output mlfq_pkg::sts_t        sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mlfq_pkg::result_t     out_data
);
	mlfq_pkg::row_t    mem [mlfq_pkg::SLOTS];
	logic [mlfq_pkg::SLOTS-1:0] valid_q;

	logic [2:0]                  cmd_q;
	logic [mlfq_pkg::SLOT_W-1:0] slot_q;
	logic [31:0]                 chan_q;
	logic [15:0]                 age_q;
	logic [63:0]                 stamp_q;
	logic [mlfq_pkg::SLOT_W-1:0] idx_q;

	logic                        found_q;
	logic [mlfq_pkg::SLOT_W-1:0] best_q;
	logic [mlfq_pkg::LVL_W-1:0]  best_lvl_q;
	logic [63:0]                 best_stamp_q;

	mlfq_pkg::result_t res_q;

	mlfq_pkg::row_t              rd_s1;
	logic                        vld_s1;
	logic                        act_s1;
	mlfq_pkg::rd_kind_t          kind_s1;
	logic [mlfq_pkg::SLOT_W-1:0] addr_s1;

	logic [mlfq_pkg::SLOT_W-1:0] rd_addr;
	mlfq_pkg::row_t              e, n;
	logic                        take_stamp, bad, cand;
	logic [mlfq_pkg::BURST_W-1:0] bplus;

	always_comb begin
		case (ctl.rd_kind)
			mlfq_pkg::RD_SLOT: rd_addr = slot_q;
			mlfq_pkg::RD_BEST: rd_addr = best_q;
			default:           rd_addr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) rd_s1 <= mem[rd_addr];
		if (act_s1) mem[addr_s1] <= n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1  <= 1'b0;
			vld_s1  <= 1'b0;
			valid_q <= '0;
		end else begin
			act_s1 <= ctl.rd_en;
			if (ctl.rd_en) vld_s1 <= valid_q[rd_addr];
			if (act_s1) valid_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			kind_s1 <= ctl.rd_kind;
			addr_s1 <= rd_addr;
		end
	end

	always_comb begin
		e          = vld_s1 ? rd_s1 : '0;
		n          = e;
		take_stamp = 1'b0;
		bad        = 1'b0;
		bplus      = e.burst + mlfq_pkg::BURST_W'(1);
		case (kind_s1)
			mlfq_pkg::RD_SWEEP: begin
				case (cmd_q)
					mlfq_pkg::CMD_PICK: begin
						if (e.st == mlfq_pkg::TS_RUNNABLE && e.wcnt > age_q) begin
							n.wcnt  = '0;
							n.burst = '0;
							if (e.lvl != '0) begin
								n.lvl      = e.lvl - mlfq_pkg::LVL_W'(1);
								n.stamp    = stamp_q;
								take_stamp = 1'b1;
							end
						end
					end
					mlfq_pkg::CMD_TICK: begin
						if (e.st == mlfq_pkg::TS_RUNNING) begin
							n.run = mlfq_pkg::sat32(e.run);
							if ({4'd0, bplus} > (9'd1 << e.lvl)) begin
								n.burst = '0;
								if (32'(e.lvl) + 32'd1 < 32'(mlfq_pkg::LEVELS))
									n.lvl = e.lvl + mlfq_pkg::LVL_W'(1);
								n.stamp    = stamp_q;
								take_stamp = 1'b1;
							end else begin
								n.burst = bplus;
							end
						end else if (e.st == mlfq_pkg::TS_SLEEPING) begin
							n.slp = mlfq_pkg::sat32(e.slp);
						end else if (e.st == mlfq_pkg::TS_RUNNABLE) begin
							if (e.wcnt != 16'hFFFF) n.wcnt = e.wcnt + 16'd1;
						end
					end
					mlfq_pkg::CMD_WAKE: begin
						if (e.st == mlfq_pkg::TS_SLEEPING && e.chan == chan_q) begin
							n.wcnt     = '0;
							n.burst    = '0;
							n.stamp    = stamp_q;
							take_stamp = 1'b1;
							n.st       = mlfq_pkg::TS_RUNNABLE;
						end
					end
					default: ;
				endcase
			end
			mlfq_pkg::RD_BEST: begin
				if (e.burst == '0) n.disp = mlfq_pkg::sat32(e.disp);
				n.st = mlfq_pkg::TS_RUNNING;
			end
			default: begin
				case (cmd_q)
					mlfq_pkg::CMD_CREATE: begin
						if (e.st != mlfq_pkg::TS_UNUSED) begin
							bad = 1'b1;
						end else begin
							n.st       = mlfq_pkg::TS_RUNNABLE;
							n.lvl      = '0;
							n.burst    = '0;
							n.wcnt     = '0;
							n.run      = '0;
							n.slp      = '0;
							n.disp     = '0;
							n.stamp    = stamp_q;
							take_stamp = 1'b1;
						end
					end
					mlfq_pkg::CMD_YIELD: begin
						if (e.st != mlfq_pkg::TS_RUNNING) bad = 1'b1;
						else n.st = mlfq_pkg::TS_RUNNABLE;
					end
					mlfq_pkg::CMD_SLEEP: begin
						if (e.st != mlfq_pkg::TS_RUNNING) begin
							bad = 1'b1;
						end else begin
							n.st   = mlfq_pkg::TS_SLEEPING;
							n.chan = chan_q;
						end
					end
					mlfq_pkg::CMD_EXIT: begin
						if (e.st != mlfq_pkg::TS_RUNNING) bad = 1'b1;
						else n.st = mlfq_pkg::TS_ZOMBIE;
					end
					mlfq_pkg::CMD_COLLECT: begin
						if (e.st != mlfq_pkg::TS_ZOMBIE) bad = 1'b1;
						else n.st = mlfq_pkg::TS_UNUSED;
					end
					default: bad = 1'b1;
				endcase
			end
		endcase
		cand = (n.st == mlfq_pkg::TS_RUNNABLE) && (!found_q || n.lvl < best_lvl_q ||
			(n.lvl == best_lvl_q && n.stamp < best_stamp_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q   <= mlfq_pkg::AGING_RST;
			stamp_q <= '0;
			found_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (cfg_we) age_q <= cfg_wdata;
			if (act_s1 && take_stamp) stamp_q <= stamp_q + 64'd1;
			if (ctl.start) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (ctl.rd_en && ctl.rd_kind == mlfq_pkg::RD_SWEEP)
					idx_q <= idx_q + mlfq_pkg::SLOT_W'(1);
				if (act_s1 && kind_s1 == mlfq_pkg::RD_SWEEP && cmd_q == mlfq_pkg::CMD_PICK &&
					cand)
					found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cmd_q  <= in_cmd;
			slot_q <= in_slot;
			chan_q <= in_chan;
			res_q  <= '0;
			if (!(in_cmd inside {mlfq_pkg::CMD_PICK, mlfq_pkg::CMD_TICK,
				mlfq_pkg::CMD_WAKE}))
				res_q.chosen_slot <= in_slot;
		end else begin
			if (ctl.no_task) res_q.status <= mlfq_pkg::STAT_NO_TASK;
			if (act_s1 && kind_s1 == mlfq_pkg::RD_SWEEP && cmd_q == mlfq_pkg::CMD_PICK &&
				cand) begin
				best_q       <= addr_s1;
				best_lvl_q   <= n.lvl;
				best_stamp_q <= n.stamp;
			end
			if (act_s1 && kind_s1 != mlfq_pkg::RD_SWEEP) begin
				if (bad) begin
					res_q.status <= mlfq_pkg::STAT_BAD;
				end else if (kind_s1 == mlfq_pkg::RD_BEST ||
					cmd_q == mlfq_pkg::CMD_COLLECT) begin
					res_q.chosen_slot <= addr_s1;
					res_q.level       <= n.lvl;
					res_q.run_ticks   <= n.run;
					res_q.sleep_ticks <= n.slp;
					res_q.wait_ticks  <= n.wcnt;
					res_q.run_count   <= n.disp;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) out_data <= res_q;
	end

	assign sts.cmd      = cmd_q;
	assign sts.idx_last = (idx_q == mlfq_pkg::SLOT_W'(mlfq_pkg::SLOTS - 1));
	assign sts.found    = found_q;
	assign sts.out_free = !out_valid || out_ready;
endmodule

// ===== design/mlfq_process_scheduler.sv =====
// Top level of the multilevel feedback queue process scheduler.
// One command is taken at a time. Pick, tick and wake walk the 64-slot table
// one slot per cycle through the slot memory (one read and one write a cycle);
// pick then reads and writes back the chosen slot if one was found. Slot commands
// read their one slot and write it back. A command finishes only once the output
// register is free, so a result that is stalled delays the finish of the next
// command. The next command is accepted while a result waits. The aging
// threshold (cfg_wdata) may be written only while idle.
`timescale 1ns / 1ps
module mlfq_process_scheduler (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // command[2:0], slot[8:3], channel[40:9]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // status, chosen_slot, level, run_ticks,
	                                    // sleep_ticks, wait_ticks, run_count
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata
);
	mlfq_pkg::ctl_t    ctl;
	mlfq_pkg::sts_t    sts;
	mlfq_pkg::result_t res;

	mlfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tdata[2:0]),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	mlfq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (s_axis_tdata[2:0]),
		.in_slot   (s_axis_tdata[8:3]),
		.in_chan   (s_axis_tdata[40:9]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res)
	);

	assign m_axis_tdata = {5'd0, res};
endmodule

// ===== design/mlfq_checker.sv =====
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
module mlfq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed under stall");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("illegal status");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == 2'd1 |-> m_axis_tdata[127:2] == '0)
		else $error("empty pick carries data");
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10:8] <= 3'd4)
		else $error("level out of range");
endmodule

bind mlfq_process_scheduler mlfq_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== test/mlfq_process_scheduler_tb.sv =====
// Self-checking testbench for the feedback queue scheduler with a cycle-free predictor.
`timescale 1ns / 1ps
module mlfq_process_scheduler_tb;
	import mlfq_pkg::*;

	typedef struct {
		logic [2:0]  cmd;
		logic [5:0]  slot;
		logic [31:0] chan;
	} sched_cmd_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [47:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = '0;

	mlfq_process_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sched_cmd_t cmd_q[$];
	result_t    expected_results[$];
	int         errors = 0;
	bit         quiet = 1'b0;

	// scheduler shadow state
	logic [15:0]     age_lim = AGING_RST;
	logic [2:0]      t_st[SLOTS];
	logic [2:0]      t_lvl[SLOTS];
	int              t_burst[SLOTS];
	logic [15:0]     t_wait[SLOTS];
	logic [31:0]     t_run[SLOTS];
	logic [31:0]     t_slp[SLOTS];
	logic [31:0]     t_disp[SLOTS];
	logic [31:0]     t_chan[SLOTS];
	longint unsigned t_stamp[SLOTS];
	longint unsigned next_stamp = 0;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			t_st[i] = TS_UNUSED; t_lvl[i] = '0; t_burst[i] = 0; t_wait[i] = '0;
			t_run[i] = '0; t_slp[i] = '0; t_disp[i] = '0; t_chan[i] = '0; t_stamp[i] = 0;
		end
	end

	function automatic logic [31:0] bump32(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic void restamp(int s);
		t_stamp[s] = next_stamp;
		next_stamp++;
	endfunction

	function automatic void fill_report(ref result_t r, input int s);
		r.chosen_slot = s[5:0];
		r.level = t_lvl[s];
		r.run_ticks = t_run[s];
		r.sleep_ticks = t_slp[s];
		r.wait_ticks = t_wait[s];
		r.run_count = t_disp[s];
	endfunction

	function automatic result_t schedule_outcome(sched_cmd_t c);
		result_t r;
		int s;
		int best;
		bit found;
		r = '0;
		s = c.slot;
		r.chosen_slot = c.slot;
		r.status = STAT_DONE;
		case (c.cmd)
			CMD_CREATE: begin
				if (t_st[s] != TS_UNUSED) r.status = STAT_BAD;
				else begin
					t_st[s] = TS_RUNNABLE; t_lvl[s] = '0; t_burst[s] = 0; t_wait[s] = '0;
					t_run[s] = '0; t_slp[s] = '0; t_disp[s] = '0;
					restamp(s);
				end
			end
			CMD_PICK: begin
				r.chosen_slot = '0;
				for (int i = 0; i < SLOTS; i++)
					if (t_st[i] == TS_RUNNABLE && t_wait[i] > age_lim) begin
						t_wait[i] = '0; t_burst[i] = 0;
						if (t_lvl[i] > 0) begin
							t_lvl[i]--;
							restamp(i);
						end
					end
				found = 1'b0; best = 0;
				for (int lv = 0; lv < LEVELS && !found; lv++)
					for (int i = 0; i < SLOTS; i++)
						if (t_st[i] == TS_RUNNABLE && t_lvl[i] == lv) begin
							if (!found || t_stamp[i] < t_stamp[best]) best = i;
							found = 1'b1;
						end
				if (!found) r.status = STAT_NO_TASK;
				else begin
					if (t_burst[best] == 0) t_disp[best] = bump32(t_disp[best]);
					t_st[best] = TS_RUNNING;
					fill_report(r, best);
				end
			end
			CMD_TICK: begin
				r.chosen_slot = '0;
				for (int i = 0; i < SLOTS; i++)
					if (t_st[i] == TS_RUNNING) begin
						t_run[i] = bump32(t_run[i]);
						t_burst[i]++;
						if (t_burst[i] > (1 << t_lvl[i])) begin
							t_burst[i] = 0;
							if (t_lvl[i] + 1 < LEVELS) t_lvl[i]++;
							restamp(i);
						end
					end else if (t_st[i] == TS_SLEEPING)
						t_slp[i] = bump32(t_slp[i]);
					else if (t_st[i] == TS_RUNNABLE && t_wait[i] != 16'hFFFF)
						t_wait[i]++;
			end
			CMD_YIELD, CMD_SLEEP, CMD_EXIT: begin
				if (t_st[s] != TS_RUNNING) r.status = STAT_BAD;
				else if (c.cmd == CMD_YIELD) t_st[s] = TS_RUNNABLE;
				else if (c.cmd == CMD_EXIT) t_st[s] = TS_ZOMBIE;
				else begin
					t_st[s] = TS_SLEEPING;
					t_chan[s] = c.chan;
				end
			end
			CMD_WAKE: begin
				r.chosen_slot = '0;
				for (int i = 0; i < SLOTS; i++)
					if (t_st[i] == TS_SLEEPING && t_chan[i] == c.chan) begin
						t_wait[i] = '0; t_burst[i] = 0;
						restamp(i);
						t_st[i] = TS_RUNNABLE;
					end
			end
			default: begin
				if (t_st[s] != TS_ZOMBIE) r.status = STAT_BAD;
				else begin
					fill_report(r, s);
					t_st[s] = TS_UNUSED;
				end
			end
		endcase
		return r;
	endfunction

	// driver
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		sched_cmd_t c;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			src_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				c.cmd = s_axis_tdata[2:0];
				c.slot = s_axis_tdata[8:3];
				c.chan = s_axis_tdata[40:9];
				expected_results.push_back(schedule_outcome(c));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_q.size() > 0) begin
					c = cmd_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {7'd0, c.chan, c.slot, c.cmd};
					if (!quiet && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 12);
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	int sink_stall = 0;
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(result_t)-1:0];
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction, actual %h", $realtime, got);
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.chosen_slot !== want.chosen_slot ||
					    got.level !== want.level || got.run_ticks !== want.run_ticks ||
					    got.sleep_ticks !== want.sleep_ticks ||
					    got.wait_ticks !== want.wait_ticks ||
					    got.run_count !== want.run_count) begin
						errors++;
						$display("%0t: mismatch expected %h actual %h", $realtime, want, got);
					end
				end
			end
			if (sink_stall > 0) begin
				sink_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) sink_stall = $urandom_range(1, 12);
			end
		end
	end

	function automatic void add_cmd(logic [2:0] cmd, logic [5:0] slot, logic [31:0] chan);
		sched_cmd_t c;
		c.cmd = cmd; c.slot = slot; c.chan = chan;
		cmd_q.push_back(c);
	endfunction

	function automatic logic [31:0] pick_chan();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2, 3: return 32'h5;
			4, 5: return 32'hA5A5_5A5A;
			6: return 32'h7;
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_random(int n);
		int w;
		logic [2:0] cmd;
		logic [5:0] slot;
		for (int i = 0; i < n; i++) begin
			w = $urandom_range(0, 99);
			if (w < 12) cmd = CMD_CREATE;
			else if (w < 30) cmd = CMD_PICK;
			else if (w < 58) cmd = CMD_TICK;
			else if (w < 66) cmd = CMD_YIELD;
			else if (w < 74) cmd = CMD_SLEEP;
			else if (w < 82) cmd = CMD_WAKE;
			else if (w < 90) cmd = CMD_EXIT;
			else cmd = CMD_COLLECT;
			slot = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
			add_cmd(cmd, slot, pick_chan());
		end
	endfunction

	task automatic drain();
		while (cmd_q.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_aging_threshold(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		age_lim = v;
	endtask

	initial begin
		logic [15:0] limits[6];
		limits = '{16'd40, 16'd0, 16'd65535, 16'd3, 16'd1, 16'd12};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed opener
		add_cmd(CMD_PICK, 6'd0, 32'h0);
		add_cmd(CMD_CREATE, 6'd0, 32'h0);
		add_cmd(CMD_CREATE, 6'd63, 32'hFFFF_FFFF);
		add_cmd(CMD_CREATE, 6'd0, 32'h0);
		add_cmd(CMD_YIELD, 6'd0, 32'h0);
		add_cmd(CMD_PICK, 6'd0, 32'h0);
		add_cmd(CMD_PICK, 6'd0, 32'h0);
		add_cmd(CMD_PICK, 6'd0, 32'h0);
		add_cmd(CMD_TICK, 6'd0, 32'h0);
		add_cmd(CMD_TICK, 6'd0, 32'h0);
		add_cmd(CMD_SLEEP, 6'd63, 32'hFFFF_FFFF);
		add_cmd(CMD_TICK, 6'd0, 32'h0);
		add_cmd(CMD_WAKE, 6'd0, 32'h0);
		add_cmd(CMD_WAKE, 6'd0, 32'hFFFF_FFFF);
		add_cmd(CMD_YIELD, 6'd0, 32'h0);
		add_cmd(CMD_PICK, 6'd0, 32'h0);
		add_cmd(CMD_EXIT, 6'd63, 32'h0);
		add_cmd(CMD_COLLECT, 6'd63, 32'h0);
		add_cmd(CMD_COLLECT, 6'd63, 32'h0);
		add_cmd(CMD_SLEEP, 6'd5, 32'h0);
		add_cmd(CMD_EXIT, 6'd42, 32'h0);
		add_cmd(CMD_PICK, 6'd0, 32'h0);
		for (int p = 0; p < 6; p++) begin
			if (p > 0) write_aging_threshold(limits[p]);
			quiet = (p == 5);
			add_random(300);
			drain();
		end
		if (errors == 0)
			$display("mlfq_process_scheduler_tb OK");
		else
			$display("mlfq_process_scheduler_tb NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("mlfq_process_scheduler_tb NOT OK");
		$finish;
	end
endmodule

// ===== files.f =====
design/mlfq_pkg.sv
design/mlfq_ctrl.sv
design/mlfq_datapath.sv
design/mlfq_process_scheduler.sv
design/mlfq_checker.sv
test/mlfq_process_scheduler_tb.sv
